FILE: hw/rtl/mbt_pkg.sv
package mbt_pkg;

    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int FUNC_W     = 2;
    localparam int IN_VAL_W   = 32;
    localparam int OUT_CNT_W  = 5;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 16;

    typedef enum logic [FUNC_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // search token walking down the cell row
    typedef struct packed {
        logic                  active;
        logic [VALUE_BITS-1:0] value;
        logic [CNT_W-1:0]      freq;
        logic                  hit;
        logic [SLOT_W-1:0]     hit_slot;
        logic [VALUE_BITS-1:0] last_val;
    } probe_t;

    // write port broadcast to all cells
    typedef struct packed {
        logic                  en;
        logic [SLOT_W-1:0]     slot;
        logic [VALUE_BITS-1:0] data;
    } wr_t;

endpackage

FILE: hw/rtl/mbt_cell.sv
module mbt_cell
    import mbt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [SLOT_W-1:0] idx,
    input  logic [CNT_W-1:0]  count,
    input  wr_t               wr,
    input  probe_t            tok_in,
    output probe_t            tok_out
);

    logic [VALUE_BITS-1:0] entry_reg;
    probe_t                tok_reg;
    probe_t                tok_next;
    logic                  occupied;
    logic                  match;
    logic                  is_last;

    assign occupied = (CNT_W'(idx) < count);
    assign match    = occupied && (entry_reg == tok_in.value);
    assign is_last  = ((CNT_W'(idx) + CNT_W'(1)) == count);

    always_comb begin
        tok_next = tok_in;
        if (match) begin
            tok_next.freq     = tok_in.freq + CNT_W'(1);
            tok_next.hit      = 1'b1;
            tok_next.hit_slot = idx;
        end
        if (is_last) begin
            tok_next.last_val = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.active <= 1'b0;
        end else begin
            tok_reg.active <= tok_next.active;
        end
        tok_reg.value    <= tok_next.value;
        tok_reg.freq     <= tok_next.freq;
        tok_reg.hit      <= tok_next.hit;
        tok_reg.hit_slot <= tok_next.hit_slot;
        tok_reg.last_val <= tok_next.last_val;
    end

    always_ff @(posedge aclk) begin
        if (wr.en && (wr.slot == idx)) begin
            entry_reg <= wr.data;
        end
    end

    assign tok_out = tok_reg;

endmodule

FILE: hw/rtl/multiset_bag_table.sv
// Channel | Dir | Ports                     | Item
// s_      | in  | s_tvalid s_tready s_tdata | func, value
// m_      | out | m_tvalid m_tready m_tdata | ok, frequency, found, size, empty_res
//
// One item at a time: the search token walks the row of CAPACITY entry cells, one
// cell per cycle, then the row's tail is latched and the result written back.
// Reset empties the bag; entry contents stay undefined until written.
// The result register frees s_tready for the next item while a result waits;
// write-back holds until the result register is free.
module multiset_bag_table
    import mbt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // func[1:0], value[33:2]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata   // ok[0], frequency[5:1], found[6],
                                          // size[11:7], empty_res[12]
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SWEEP  = 3'b010,
        ST_RESULT = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    op_t                   func_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    probe_t                tail_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;

    probe_t                chain [0:CAPACITY];
    wr_t                   wr;
    logic                  in_acc;
    logic                  out_free;
    logic                  do_wb;
    logic                  ok;
    logic [IN_VAL_W-1:0]   in_value;

    assign in_value = s_tdata[FUNC_W +: IN_VAL_W];
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign do_wb    = (state_reg == ST_RESULT) && out_free;

    assign chain[0] = {in_acc, VALUE_BITS'(in_value),
                       {(CNT_W + 1 + SLOT_W + VALUE_BITS){1'b0}}};

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        mbt_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .idx     (SLOT_W'(g)),
            .count   (count_reg),
            .wr      (wr),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_acc) state_next = ST_SWEEP;
            ST_SWEEP:  if (chain[CAPACITY].active) state_next = ST_RESULT;
            ST_RESULT: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        wr         = '0;
        ok         = 1'b1;
        count_next = count_reg;
        unique case (func_reg)
            OP_ADD: begin
                if (count_reg < CNT_W'(CAPACITY)) begin
                    wr.en      = do_wb;
                    wr.slot    = count_reg[SLOT_W-1:0];
                    wr.data    = tail_reg.value;
                    count_next = count_reg + CNT_W'(1);
                end else begin
                    ok = 1'b0;
                end
            end
            OP_REMOVE: begin
                if (tail_reg.hit) begin
                    wr.en      = do_wb;
                    wr.slot    = tail_reg.hit_slot;
                    wr.data    = tail_reg.last_val;
                    count_next = count_reg - CNT_W'(1);
                end else begin
                    ok = 1'b0;
                end
            end
            OP_QUERY: ;
            OP_CLEAR: count_next = '0;
            default:  ;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (do_wb) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tdata_next[0]   = ok;
            m_tdata_next[5:1] = OUT_CNT_W'(tail_reg.freq);
            m_tdata_next[6]   = tail_reg.hit;
            m_tdata_next[11:7] = OUT_CNT_W'(count_next);
            m_tdata_next[12]  = (count_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (do_wb) begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        if (in_acc) begin
            func_reg <= op_t'(s_tdata[FUNC_W-1:0]);
        end
        if ((state_reg == ST_SWEEP) && chain[CAPACITY].active) begin
            tail_reg <= chain[CAPACITY];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_found_freq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[6] == (m_tdata[5:1] != 5'd0)))
        else $error("found disagrees with frequency");

    a_tail_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        chain[CAPACITY].active |-> (state_reg == ST_SWEEP))
        else $error("search token left the row outside a sweep");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> (state_reg == ST_SWEEP))
        else $error("item accepted without a sweep");

endmodule

FILE: tb/sv/tb_multiset_bag_table.sv
module tb_multiset_bag_table;
    timeunit 1ns;
    timeprecision 1ps;

    import mbt_pkg::*;

    localparam int unsigned N_RANDOM = 1900;
    localparam int unsigned WATCHDOG = 3000;
    localparam int unsigned HOLD_AT  = 300;
    localparam int unsigned HOLD_LEN = 500;

    typedef struct packed {
        logic                 empty_res;
        logic [OUT_CNT_W-1:0] size;
        logic                 found;
        logic [OUT_CNT_W-1:0] frequency;
        logic                 ok;
    } bag_result_t;

    typedef struct {
        op_t                 op;
        logic [IN_VAL_W-1:0] value;
    } bag_cmd_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    multiset_bag_table i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bag_cmd_t    stim_items[$];
    bag_result_t bag_expected[$];

    logic [VALUE_BITS-1:0] bag_slots [CAPACITY];
    int unsigned           bag_count = 0;

    int unsigned mismatches  = 0;
    int unsigned idle_cycles = 0;
    int unsigned in_gap      = 0;
    int unsigned in_sent     = 0;
    int unsigned out_wait    = 0;
    int unsigned out_seen    = 0;
    bit          in_taken    = 1'b0;
    bit          out_taken   = 1'b0;

    function automatic bag_result_t bag_apply(op_t op, logic [IN_VAL_W-1:0] value);
        logic [VALUE_BITS-1:0] v;
        int unsigned           freq;
        int unsigned           hit_slot;
        logic                  ok;
        bag_result_t           r;
        v        = value[VALUE_BITS-1:0];
        freq     = 0;
        hit_slot = 0;
        ok       = 1'b1;
        for (int i = 0; i < bag_count; i++) begin
            if (bag_slots[i] == v) begin
                freq++;
                hit_slot = i;
            end
        end
        case (op)
            OP_ADD: begin
                if (bag_count < CAPACITY) begin
                    bag_slots[bag_count] = v;
                    bag_count++;
                end else begin
                    ok = 1'b0;
                end
            end
            OP_REMOVE: begin
                // newest match takes the newest entry
                if (freq != 0) begin
                    bag_slots[hit_slot] = bag_slots[bag_count - 1];
                    bag_count--;
                end else begin
                    ok = 1'b0;
                end
            end
            OP_QUERY: begin
            end
            default: begin
                bag_count = 0;
            end
        endcase
        r.ok        = ok;
        r.frequency = freq[OUT_CNT_W-1:0];
        r.found     = (freq != 0);
        r.size      = bag_count[OUT_CNT_W-1:0];
        r.empty_res = (bag_count == 0);
        return r;
    endfunction

    task automatic push_cmd(op_t op, logic [IN_VAL_W-1:0] value);
        bag_cmd_t c;
        c.op    = op;
        c.value = value;
        stim_items.insert(stim_items.size(), c);
    endtask

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // input driver
    always @(negedge aclk) begin : drive_in
        bag_cmd_t c;
        if (aresetn) begin
            if (s_tvalid && in_taken) begin
                in_gap = ((in_sent / 250) % 4 == 3) ? 0 : $urandom_range(0, 15);
            end
            if (s_tvalid && !in_taken) begin
                // hold item until accepted
            end else if (in_gap > 0) begin
                in_gap--;
                s_tvalid <= 1'b0;
            end else if (stim_items.size() != 0) begin
                c = stim_items.pop_front();
                s_tdata  <= {{(S_DATA_W - IN_VAL_W - FUNC_W){1'b0}}, c.value, c.op};
                s_tvalid <= 1'b1;
                in_sent++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off to back up the input
    always @(negedge aclk) begin : drive_out
        if (aresetn) begin
            if (out_taken) begin
                out_seen++;
                if (out_seen == HOLD_AT) begin
                    out_wait = HOLD_LEN;
                end else begin
                    out_wait = ((out_seen / 200) % 4 == 1) ? 0 : $urandom_range(0, 15);
                end
            end
            if (out_wait > 0) begin
                out_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : monitor
        bag_result_t want;
        bag_result_t got;
        in_taken  <= s_tvalid && s_tready;
        out_taken <= m_tvalid && m_tready;
        if (s_tvalid && s_tready) begin
            bag_expected.insert(bag_expected.size(),
                                bag_apply(op_t'(s_tdata[FUNC_W-1:0]),
                                          s_tdata[FUNC_W+IN_VAL_W-1:FUNC_W]));
        end
        if (m_tvalid && m_tready) begin
            got = m_tdata[$bits(bag_result_t)-1:0];
            if (bag_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result item: ok=%0d freq=%0d found=%0d",
                             got.ok, got.frequency, got.found);
                    $display("          size=%0d empty=%0d", got.size, got.empty_res);
                end
            end else begin
                want = bag_expected.pop_front();
                if (got.ok !== want.ok || got.frequency !== want.frequency ||
                    got.found !== want.found || got.size !== want.size ||
                    got.empty_res !== want.empty_res) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp ok=%0d freq=%0d found=%0d size=%0d empty=%0d",
                                 want.ok, want.frequency, want.found, want.size,
                                 want.empty_res);
                        $display("          got ok=%0d freq=%0d found=%0d size=%0d empty=%0d",
                                 got.ok, got.frequency, got.found, got.size, got.empty_res);
                    end
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == WATCHDOG) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        logic [IN_VAL_W-1:0] pool [4];
        logic [IN_VAL_W-1:0] v;
        int unsigned         phase;
        int unsigned         pick;
        op_t                 op;

        // empty bag corner cases
        push_cmd(OP_CLEAR,  32'h0);
        push_cmd(OP_REMOVE, 32'h0);
        push_cmd(OP_ADD,    32'hFFFF_FFFF);
        push_cmd(OP_ADD,    32'hFFFF_FFFF);
        push_cmd(OP_QUERY,  32'hFFFF_FFFF);
        push_cmd(OP_REMOVE, 32'hFFFF_FFFF);
        push_cmd(OP_REMOVE, 32'h5);
        push_cmd(OP_REMOVE, 32'hFFFF_FFFF);
        push_cmd(OP_QUERY,  32'h0);
        // fill to capacity with one value, then add when full
        for (int i = 0; i < CAPACITY; i++) begin
            push_cmd(OP_ADD, 32'h0);
        end
        push_cmd(OP_ADD,    32'h0);
        push_cmd(OP_QUERY,  32'hFFFF_FFFF);
        push_cmd(OP_CLEAR,  32'hA5A5_A5A5);

        pool[0] = 32'h0;
        pool[1] = 32'hFFFF_FFFF;
        pool[2] = $urandom;
        pool[3] = $urandom;
        for (int n = 0; n < N_RANDOM; n++) begin
            phase = (n / 150) % 3;
            pick  = $urandom_range(0, 99);
            case (phase)
                0: op = (pick < 60) ? OP_ADD : (pick < 75) ? OP_REMOVE :
                        (pick < 99) ? OP_QUERY : OP_CLEAR;
                1: op = (pick < 20) ? OP_ADD : (pick < 75) ? OP_REMOVE :
                        (pick < 98) ? OP_QUERY : OP_CLEAR;
                default: op = (pick < 40) ? OP_ADD : (pick < 70) ? OP_REMOVE :
                              (pick < 98) ? OP_QUERY : OP_CLEAR;
            endcase
            if ($urandom_range(0, 99) < 75) begin
                v = pool[$urandom_range(0, 3)];
            end else begin
                v = $urandom;
            end
            push_cmd(op, v);
        end

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (stim_items.size() != 0 || s_tvalid) @(posedge aclk);
        while (bag_expected.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (mismatches == 0 && bag_expected.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
